// ===== hdl/spq_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types of the sorted priority queue.
// Depends on nothing; spq_ctrl and the top level import it.
package spq_pkg;

    localparam int KEY_W           = 32;
    localparam int LABEL_MAX_BYTES = 20;
    localparam int LABEL_MAX_W     = LABEL_MAX_BYTES * 8;
    localparam int OCC_W           = 5;
    localparam int STATUS_W        = 2;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_LABEL_BYTES = 20;

    // Stream payload widths: key and name bytes in, key, name and occupancy out.
    localparam int S_TDATA_W = KEY_W + LABEL_MAX_W;
    localparam int M_RAW_W   = KEY_W + LABEL_MAX_W + OCC_W;
    localparam int M_TDATA_W = ((M_RAW_W + 7) / 8) * 8;

    typedef logic [STATUS_W-1:0] status_t;

    localparam logic    CMD_INSERT = 1'b0;
    localparam logic    CMD_REMOVE = 1'b1;

    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

endpackage

// ===== hdl/spq_store.sv =====
`timescale 1ns / 1ps
// Entry memory of the sorted priority queue: one write port, one read port,
// registered read data. Depends on nothing else.
module spq_store #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 192,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/spq_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the sorted priority queue: head pointer, fill count and the
// insertion walk over the entry memory. Depends on spq_pkg.
module spq_ctrl #(
    parameter int QUEUE_DEPTH = 16,
    parameter int LABEL_BYTES = 20,
    parameter int ADDR_W      = 4,
    parameter int FILL_W      = 5,
    parameter int ENTRY_W     = 192
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              in_cmd,
    input  logic signed [spq_pkg::KEY_W-1:0]  in_key,
    input  logic [spq_pkg::LABEL_MAX_W-1:0]   in_name,
    output logic                              res_valid,
    input  logic                              res_ready,
    output spq_pkg::status_t                  res_status,
    output logic signed [spq_pkg::KEY_W-1:0]  res_key,
    output logic [LABEL_BYTES*8-1:0]          res_name,
    output logic [spq_pkg::OCC_W-1:0]         res_occ,
    output logic                              mem_wr_en,
    output logic [ADDR_W-1:0]                 mem_wr_addr,
    output logic [ENTRY_W-1:0]                mem_wr_data,
    output logic                              mem_rd_en,
    output logic [ADDR_W-1:0]                 mem_rd_addr,
    input  logic [ENTRY_W-1:0]                mem_rd_data
);
    import spq_pkg::*;

    localparam int NAME_W = LABEL_BYTES * 8;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_PLACE  = 3'd2;
    localparam logic [2:0] S_HEAD   = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    localparam logic [ADDR_W:0] DEPTH_W1 = (ADDR_W + 1)'(QUEUE_DEPTH);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);

    logic [2:0]               state_reg,  state_next;
    logic [FILL_W-1:0]        fill_reg,   fill_next;
    logic [ADDR_W-1:0]        head_reg,   head_next;
    logic [ADDR_W-1:0]        pos_reg,    pos_next;
    logic signed [KEY_W-1:0]  key_reg,    key_next;
    logic [NAME_W-1:0]        name_reg,   name_next;
    status_t                  status_reg, status_next;
    logic signed [KEY_W-1:0]  rkey_reg,   rkey_next;
    logic [NAME_W-1:0]        rname_reg,  rname_next;

    logic signed [KEY_W-1:0]  rd_key;
    logic [FILL_W+OCC_W-1:0]  fill_ext;

    // Logical slot (0 is the head) to memory address, modulo the depth.
    function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] head,
                                               input logic [ADDR_W-1:0] slot);
        logic [ADDR_W:0] sum;
        sum = {1'b0, head} + {1'b0, slot};
        if (sum >= DEPTH_W1) begin
            sum = sum - DEPTH_W1;
        end
        return sum[ADDR_W-1:0];
    endfunction

    assign rd_key = mem_rd_data[ENTRY_W-1 -: KEY_W];

    always_comb begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        head_next   = head_reg;
        pos_next    = pos_reg;
        key_next    = key_reg;
        name_next   = name_reg;
        status_next = status_reg;
        rkey_next   = rkey_reg;
        rname_next  = rname_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = phys(head_reg, pos_reg);
        mem_wr_data = {key_reg, name_reg};
        mem_rd_en   = 1'b0;
        mem_rd_addr = phys(head_reg, pos_reg - 1'b1);

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    key_next    = in_key;
                    name_next   = in_name[NAME_W-1:0];
                    status_next = ST_DONE;
                    rkey_next   = '0;
                    rname_next  = '0;
                    pos_next    = fill_reg[ADDR_W-1:0];
                    if (in_cmd == CMD_INSERT) begin
                        if (fill_reg == FILL_FULL) begin
                            status_next = ST_FULL;
                            state_next  = S_RESULT;
                        end else if (fill_reg == '0) begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = head_reg;
                            mem_wr_data = {in_key, in_name[NAME_W-1:0]};
                            fill_next   = fill_reg + 1'b1;
                            state_next  = S_RESULT;
                        end else begin
                            // Walk up from the tail, one held entry per cycle.
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = phys(head_reg, fill_reg[ADDR_W-1:0] - 1'b1);
                            state_next  = S_CHECK;
                        end
                    end else begin
                        if (fill_reg == '0) begin
                            status_next = ST_EMPTY;
                            state_next  = S_RESULT;
                        end else begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = head_reg;
                            state_next  = S_HEAD;
                        end
                    end
                end
            end
            S_CHECK: begin
                // Read data holds slot pos-1; the write goes to slot pos.
                mem_wr_en = 1'b1;
                if (rd_key >= key_reg) begin
                    fill_next  = fill_reg + 1'b1;
                    state_next = S_RESULT;
                end else begin
                    mem_wr_data = mem_rd_data;
                    pos_next    = pos_reg - 1'b1;
                    if (pos_reg == ADDR_W'(1)) begin
                        state_next = S_PLACE;
                    end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = phys(head_reg, pos_reg - ADDR_W'(2));
                    end
                end
            end
            S_PLACE: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = head_reg;
                fill_next   = fill_reg + 1'b1;
                state_next  = S_RESULT;
            end
            S_HEAD: begin
                rkey_next  = rd_key;
                rname_next = mem_rd_data[NAME_W-1:0];
                head_next  = phys(head_reg, ADDR_W'(1));
                fill_next  = fill_reg - 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            head_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        key_reg    <= key_next;
        name_reg   <= name_next;
        status_reg <= status_next;
        rkey_reg   <= rkey_next;
        rname_reg  <= rname_next;
    end

    assign fill_ext   = {{OCC_W{1'b0}}, fill_reg};
    assign in_ready   = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_RESULT);
    assign res_status = status_reg;
    assign res_key    = rkey_reg;
    assign res_name   = rname_reg;
    assign res_occ    = fill_ext[OCC_W-1:0];

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_FULL)
        else $error("fill count above queue depth");

    a_walk_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHECK) |-> (pos_reg != '0) && (fill_reg != '0))
        else $error("insertion walk at the head slot or on an empty queue");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
        else $error("read and write of the same entry in one cycle");

    a_head_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_HEAD) |=> (fill_reg == $past(fill_reg) - 1'b1))
        else $error("removal did not lower the fill count");

    a_full_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESULT && status_reg == ST_FULL) |-> (fill_reg == FILL_FULL))
        else $error("full status while the queue has room");
`endif

endmodule

// ===== hdl/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// Sorted priority queue: the top level with stream ports and the result register.
// Depends on spq_pkg, spq_store and spq_ctrl.
//
// Bounded priority queue kept in descending key order; each entry is a signed
// 32-bit key and a name of LABEL_BYTES bytes (bytes beyond that read back as
// zero). An insert (s_tuser = 0) goes behind every held entry with a greater or
// equal key, so equal keys leave in arrival order; a removal (s_tuser = 1)
// takes the head. Each input transfer yields exactly one result transfer with
// a status on m_tuser (done, empty on removal, full on insert, in which case
// the entry is dropped), the removed key and name (zero unless an entry was
// removed) and the occupancy after the item. One item is worked at a time:
// full, empty and first-entry cases go straight to the result, a removal
// first reads the head entry, and any other insert walks from the tail over
// each held entry with a smaller key, moving it one slot back. When the new
// entry becomes the head, the final compare is replaced by the head slot write.
// The insert time comes from the walk from the tail through the entry memory,
// which has one read and one write port: one entry is read and moved each
// cycle; removals only advance a head pointer.
// The result sits in an output register, so the next item is taken as soon as
// the sequencer is free even while an earlier result has not been taken, and
// the sequencer then waits only if it finishes before that register empties.
// No clearing pass follows reset; memory entries are read only after written.
module sorted_priority_queue #(
    parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH,
    parameter int LABEL_BYTES = spq_pkg::DEF_LABEL_BYTES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // key_value[31:0], label_bytes_lo[95:32], label_bytes_mid[159:96],
    // label_bytes_hi[191:160]
    input  logic [spq_pkg::S_TDATA_W-1:0]   s_tdata,
    // command[0]
    input  logic [0:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // removed_key[31:0], removed_label_lo[95:32], removed_label_mid[159:96],
    // removed_label_hi[191:160], occupancy[196:192], zero above
    output logic [spq_pkg::M_TDATA_W-1:0]   m_tdata,
    // status[1:0]
    output logic [spq_pkg::STATUS_W-1:0]    m_tuser
);
    import spq_pkg::*;

    localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int NAME_W  = LABEL_BYTES * 8;
    localparam int ENTRY_W = KEY_W + NAME_W;

    logic                     res_valid;
    logic                     res_ready;
    status_t                  res_status;
    logic signed [KEY_W-1:0]  res_key;
    logic [NAME_W-1:0]        res_name;
    logic [OCC_W-1:0]         res_occ;
    logic [LABEL_MAX_W-1:0]   res_name_ext;

    logic                     mem_wr_en;
    logic [ADDR_W-1:0]        mem_wr_addr;
    logic [ENTRY_W-1:0]       mem_wr_data;
    logic                     mem_rd_en;
    logic [ADDR_W-1:0]        mem_rd_addr;
    logic [ENTRY_W-1:0]       mem_rd_data;

    logic                     m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]     m_tdata_reg,  m_tdata_next;
    status_t                  m_tuser_reg,  m_tuser_next;

    spq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LABEL_BYTES (LABEL_BYTES),
        .ADDR_W      (ADDR_W),
        .FILL_W      (FILL_W),
        .ENTRY_W     (ENTRY_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (s_tuser[0]),
        .in_key      (s_tdata[KEY_W-1:0]),
        .in_name     (s_tdata[S_TDATA_W-1:KEY_W]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_status  (res_status),
        .res_key     (res_key),
        .res_name    (res_name),
        .res_occ     (res_occ),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    spq_store #(
        .DEPTH   (QUEUE_DEPTH),
        .WIDTH   (ENTRY_W),
        .ADDR_W  (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Names shorter than the full 20 bytes come back zero-filled.
    assign res_name_ext = LABEL_MAX_W'(res_name);

    // The result register frees up when empty or when its transfer completes.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
            if (res_valid) begin
                m_tdata_next = M_TDATA_W'({res_occ, res_name_ext, res_key});
                m_tuser_next = res_status;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
